[hw/rtl/md5_pkg.sv]
// md5_pkg: shared constants, types and round tables for the MD5 engine.
// No dependencies.
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hefcdab89;
   localparam logic [31:0] INIT_H2 = 32'h98badcfe;
   localparam logic [31:0] INIT_H3 = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r;
      begin
         case ({i[5:4], i[1:0]})
            4'b0000: r = 5'd7;
            4'b0001: r = 5'd12;
            4'b0010: r = 5'd17;
            4'b0011: r = 5'd22;
            4'b0100: r = 5'd5;
            4'b0101: r = 5'd9;
            4'b0110: r = 5'd14;
            4'b0111: r = 5'd20;
            4'b1000: r = 5'd4;
            4'b1001: r = 5'd11;
            4'b1010: r = 5'd16;
            4'b1011: r = 5'd23;
            4'b1100: r = 5'd6;
            4'b1101: r = 5'd10;
            4'b1110: r = 5'd15;
            default: r = 5'd21;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] sine_const(input logic [5:0] i);
      logic [31:0] k;
      begin
         case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

endpackage

[hw/rtl/md5_digest_engine.sv]
// md5_digest_engine: streaming MD5 hasher, one message byte per input word.
// Depends on md5_pkg (state enum, round tables, initial chaining values).
//
// Usage:
//   req_ channel (valid/ready): req_data_byte, req_has_byte, req_last. A
//   word with req_has_byte=1 appends a byte; req_last=1 ends the message
//   (its byte, if any, is part of it). has_byte=0, last=0 is a no-op.
//   rsp_ channel (valid/ready): rsp_digest_word0..3 = final h0..h3, one
//   word per message, after which the chain returns to the initial values.
// Timing:
//   A byte that neither fills a block nor ends the message leaves the engine
//   in ST_IDLE. The 64th byte of a block starts a compression on the single
//   shared round unit (one round per cycle), then a fold; req_ready is low till done.
//   A last word pads with one byte per cycle up to the length field, then
//   compresses once (or twice when the tail is 56 bytes or more) and holds
//   the digest in ST_OUT until rsp_ready; req_ready is low meanwhile.
// Reset: synchronous, active high; chain reset to h0..h3, count zeroed.
//   The block buffer is not cleared; padding writes every entry it reads.
module md5_digest_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3
);
   import md5_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] blk_ff [16];
   logic [31:0] h_ff [4];
   logic [31:0] w_ff [4];
   logic [60:0] cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [5:0]  pos_ff, pos_in;      // padding byte position
   logic        pend_ff, pend_in;    // last word seen, digest pending
   logic        lenpass_ff, lenpass_in; // current block holds the length

   // byte-write port into the block buffer
   logic        bwr;
   logic [5:0]  bpos;
   logic [7:0]  bval;
   logic        lwr;                 // write length words 14/15
   logic        start_cmp, fold;

   logic [63:0] bits;
   assign bits = {cnt_ff, 3'b000};

   // shared round unit
   logic [31:0] f, sum, rot, kk, mw;
   logic [3:0]  g;
   logic [4:0]  s;
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: begin
            f = (w_ff[1] & w_ff[2]) | (~w_ff[1] & w_ff[3]);
            g = rnd_ff[3:0];
         end
         2'd1: begin
            f = (w_ff[3] & w_ff[1]) | (~w_ff[3] & w_ff[2]);
            g = 4'(5 * rnd_ff + 1);
         end
         2'd2: begin
            f = w_ff[1] ^ w_ff[2] ^ w_ff[3];
            g = 4'(3 * rnd_ff + 5);
         end
         default: begin
            f = w_ff[2] ^ (w_ff[1] | ~w_ff[3]);
            g = 4'(7 * rnd_ff);
         end
      endcase
      kk  = sine_const(rnd_ff);
      s   = rot_amount(rnd_ff);
      mw  = blk_ff[g];
      sum = w_ff[0] + f + kk + mw;
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rnd_in     = rnd_ff;
      pos_in     = pos_ff;
      pend_in    = pend_ff;
      lenpass_in = lenpass_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      bwr        = 1'b0;
      bpos       = cnt_ff[5:0];
      bval       = req_data_byte;
      lwr        = 1'b0;
      start_cmp  = 1'b0;
      fold       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_has_byte) begin
                  bwr    = 1'b1;
                  cnt_in = cnt_ff + 61'd1;
               end
               pend_in = req_last;
               pos_in  = req_has_byte ? 6'(cnt_ff[5:0] + 6'd1) : cnt_ff[5:0];
               if (req_has_byte && cnt_ff[5:0] == 6'd63) begin
                  start_cmp  = 1'b1;
                  lenpass_in = 1'b0;
                  state_in   = ST_ROUND;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            fold = 1'b1;
            if (lenpass_ff)      state_in = ST_OUT;
            else if (pend_ff)    state_in = ST_PAD;
            else                 state_in = ST_IDLE;
         end
         ST_PAD: begin
            // first pad byte is 0x80 once per message; pos wraps at block end
            bwr    = 1'b1;
            bpos   = pos_ff;
            bval   = (pos_ff == cnt_ff[5:0] && !lenpass_ff && pend_ff
                      && !fold) ? PAD_BYTE : 8'h00;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd55 || pos_ff == 6'd63) begin
               if (pos_ff == 6'd55) begin
                  lwr        = 1'b1;
                  lenpass_in = 1'b1;
               end else begin
                  lenpass_in = 1'b0;
               end
               start_cmp = 1'b1;
               state_in  = ST_ROUND;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               pend_in    = 1'b0;
               lenpass_in = 1'b0;
               cnt_in     = '0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // 0x80 marker: emitted exactly once, flag tracks it
   logic mark_ff;
   logic pad_mark;
   assign pad_mark = (state_ff == ST_PAD) && !mark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rnd_ff     <= '0;
         pos_ff     <= '0;
         pend_ff    <= 1'b0;
         lenpass_ff <= 1'b0;
         mark_ff    <= 1'b0;
         h_ff[0]    <= INIT_H0;
         h_ff[1]    <= INIT_H1;
         h_ff[2]    <= INIT_H2;
         h_ff[3]    <= INIT_H3;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rnd_ff     <= rnd_in;
         pos_ff     <= pos_in;
         pend_ff    <= pend_in;
         lenpass_ff <= lenpass_in;
         if (pad_mark) mark_ff <= 1'b1;
         if (state_ff == ST_OUT && rsp_ready) begin
            mark_ff <= 1'b0;
            h_ff[0] <= INIT_H0;
            h_ff[1] <= INIT_H1;
            h_ff[2] <= INIT_H2;
            h_ff[3] <= INIT_H3;
         end else if (fold) begin
            for (int j = 0; j < 4; j++) h_ff[j] <= h_ff[j] + w_ff[j];
         end
      end
   end

   // datapath: block buffer and working registers
   logic [7:0] bdat;
   assign bdat = (state_ff == ST_PAD) ? (pad_mark ? PAD_BYTE : 8'h00) : bval;

   always_ff @(posedge clock) begin
      if (bwr) begin
         case (bpos[1:0])
            2'd0: blk_ff[bpos[5:2]][7:0]   <= bdat;
            2'd1: blk_ff[bpos[5:2]][15:8]  <= bdat;
            2'd2: blk_ff[bpos[5:2]][23:16] <= bdat;
            default: blk_ff[bpos[5:2]][31:24] <= bdat;
         endcase
      end
      if (lwr) begin
         blk_ff[14] <= bits[31:0];
         blk_ff[15] <= bits[63:32];
      end
      if (start_cmp) begin
         for (int j = 0; j < 4; j++) w_ff[j] <= h_ff[j];
      end else if (state_ff == ST_ROUND) begin
         w_ff[0] <= w_ff[3];
         w_ff[1] <= w_ff[1] + rot;
         w_ff[2] <= w_ff[1];
         w_ff[3] <= w_ff[2];
      end
   end

   assign rsp_digest_word0 = h_ff[0];
   assign rsp_digest_word1 = h_ff[1];
   assign rsp_digest_word2 = h_ff[2];
   assign rsp_digest_word3 = h_ff[3];

   // a digest only comes out of a length-carrying block
   a_out_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> lenpass_ff && pend_ff)
      else $error("digest without length block");
   a_rnd_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ROUND |-> rnd_ff == 6'd0)
      else $error("round counter not zero between blocks");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest waits");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_digest_word0) && rsp_valid)
      else $error("digest changed while stalled");
endmodule

[tb/tb.sv]
// tb: self-checking testbench for md5_digest_engine (streaming MD5 hasher).
// Depends on md5_pkg and md5_digest_engine; a local MD5 model predicts digests.
`timescale 1ns / 100ps

module tb;
   import md5_pkg::*;

   localparam int CLK_PERIOD = 12;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
   } digest_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word0;
   logic [31:0] rsp_digest_word1;
   logic [31:0] rsp_digest_word2;
   logic [31:0] rsp_digest_word3;

   md5_digest_engine u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word0 (rsp_digest_word0),
      .rsp_digest_word1 (rsp_digest_word1),
      .rsp_digest_word2 (rsp_digest_word2),
      .rsp_digest_word3 (rsp_digest_word3)
   );

   // ---------------------------------------------------------------------
   // Hash model: own copy of chain, block buffer and byte count.
   // ---------------------------------------------------------------------
   logic [31:0] mdl_chain [4];
   logic [31:0] mdl_block [16];
   logic [60:0] mdl_count;

   req_word_type pending_words[$];
   digest_type   expected_digests[$];
   int           error_count = 0;
   bit           hold_off = 0;

   // round tables kept local so the prediction does not lean on the RTL's
   function automatic logic [4:0] shift_of(int i);
      int tbl[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      return 5'(tbl[(i / 16) * 4 + (i % 4)]);
   endfunction

   function automatic logic [31:0] sine_of(int i);
      logic [31:0] tbl[64] = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return tbl[i];
   endfunction

   task automatic put_block_byte(int pos, logic [7:0] v);
      mdl_block[pos / 4][(pos % 4) * 8 +: 8] = v;
   endtask

   task automatic run_rounds();
      logic [31:0] a, b, c, d, f, t;
      int g;
      a = mdl_chain[0]; b = mdl_chain[1]; c = mdl_chain[2]; d = mdl_chain[3];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d); g = i;
         end else if (i < 32) begin
            f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
         end else if (i < 48) begin
            f = b ^ c ^ d; g = (3 * i + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7 * i) % 16;
         end
         t = a + f + sine_of(i) + mdl_block[g];
         t = (t << shift_of(i)) | (t >> (32 - shift_of(i)));
         a = d; d = c; c = b; b = b + t;
      end
      mdl_chain[0] += a; mdl_chain[1] += b; mdl_chain[2] += c; mdl_chain[3] += d;
   endtask

   task automatic restart_chain();
      mdl_chain[0] = INIT_H0; mdl_chain[1] = INIT_H1;
      mdl_chain[2] = INIT_H2; mdl_chain[3] = INIT_H3;
      mdl_count = '0;
   endtask

   // apply one accepted word; queue a digest when it ends a message
   task automatic predict_digest(req_word_type w);
      int pos;
      logic [63:0] bits;
      if (w.has_byte) begin
         pos = int'(mdl_count[5:0]);
         put_block_byte(pos, w.data_byte);
         mdl_count = mdl_count + 1'b1;
         if (pos == 63) run_rounds();
      end
      if (!w.last) return;
      pos  = int'(mdl_count[5:0]);
      bits = {mdl_count, 3'b000};
      put_block_byte(pos, PAD_BYTE);
      for (int p = pos + 1; p < 64; p++) put_block_byte(p, 8'h00);
      if (pos >= 56) begin
         run_rounds();
         for (int k = 0; k < 16; k++) mdl_block[k] = '0;
      end
      mdl_block[14] = bits[31:0];
      mdl_block[15] = bits[63:32];
      run_rounds();
      expected_digests.push_back({mdl_chain[0], mdl_chain[1], mdl_chain[2], mdl_chain[3]});
      restart_chain();
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset, watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 2_000_000);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: bursts and gaps, changes on the falling edge.
   // A word is consumed when valid & ready at the rising edge; the
   // monitor side pops it there, the driver only decides what to show next.
   // ---------------------------------------------------------------------
   int  burst_left = 0;
   int  gap_left   = 0;
   bit  accepted_q = 0;

   always @(posedge clock) begin
      accepted_q <= 1'b0;
      if (!reset && req_valid && req_ready) begin
         predict_digest(pending_words.pop_front());
         accepted_q <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= '0;
         req_has_byte  <= 1'b0;
         req_last      <= 1'b0;
      end else if (req_valid && !accepted_q) begin
         // hold the word until taken
      end else begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         // gap after the burst, plus the odd idle cycle inside it
         if (gap_left > 0 && (burst_left == 0 || $urandom_range(0, 3) == 0)) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 && !hold_off) begin
            if (burst_left > 0) burst_left--;
            req_valid     <= 1'b1;
            req_data_byte <= pending_words[0].data_byte;
            req_has_byte  <= pending_words[0].has_byte;
            req_last      <= pending_words[0].last;
         end else begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern and monitor
   // ---------------------------------------------------------------------
   int stall_phase = 0;

   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 23;
      if (reset) rsp_ready <= 1'b0;
      else if (stall_phase < 6) rsp_ready <= 1'b1;        // free-running stretch
      else rsp_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 5 != 0);
   end

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digests.size() == 0) begin
            report_mismatch("unexpected digest", rsp_digest_word0, 32'h0);
         end else begin
            want = expected_digests.pop_front();
            if (rsp_digest_word0 !== want.w0) report_mismatch("word0", rsp_digest_word0, want.w0);
            if (rsp_digest_word1 !== want.w1) report_mismatch("word1", rsp_digest_word1, want.w1);
            if (rsp_digest_word2 !== want.w2) report_mismatch("word2", rsp_digest_word2, want.w2);
            if (rsp_digest_word3 !== want.w3) report_mismatch("word3", rsp_digest_word3, want.w3);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_word(logic [7:0] b, logic h, logic l);
      req_word_type w;
      w.data_byte = b; w.has_byte = h; w.last = l;
      pending_words.push_back(w);
   endtask

   // message of n bytes; end either on the final byte or on an empty end word
   task automatic add_message(int n, int pattern);
      bit empty_end;
      logic [7:0] b;
      empty_end = (n == 0) || $urandom_range(0, 2) == 0;
      for (int i = 0; i < n; i++) begin
         case (pattern)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 15) == 0) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         add_word(b, 1'b1, (i == n - 1) && !empty_end);
      end
      if (empty_end) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || expected_digests.size() > 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int n;
      reset = 1'b1;
      restart_chain();
      for (int k = 0; k < 16; k++) mdl_block[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty message, idle words, single bytes, padding edges
      add_word(8'h00, 1'b0, 1'b1);
      add_word(8'h5a, 1'b0, 1'b0);
      add_word(8'h00, 1'b1, 1'b1);
      add_word(8'hff, 1'b1, 1'b1);
      add_message(3, 2);
      add_message(55, 0);
      add_message(56, 1);
      add_message(63, 2);
      add_message(64, 1);
      wait_drained();

      // hold the sender while a message is queued, then release it and drain
      hold_off = 1'b1;
      add_message(120, 2);
      repeat (20) @(posedge clock);
      hold_off = 1'b0;
      wait_drained();

      sent = 0;
      while (sent < 1100) begin
         case ($urandom_range(0, 4))
            0: n = $urandom_range(0, 8);
            1: n = $urandom_range(52, 68);
            2: n = $urandom_range(115, 130);
            default: n = $urandom_range(0, 70);
         endcase
         add_message(n, $urandom_range(0, 5));
         sent += n + 1;
         if ($urandom_range(0, 9) == 0) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         while (pending_words.size() > 200) @(posedge clock);
      end
      wait_drained();
      repeat (200) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
